FILE: rtl/pbbf_pkg.sv
// Shared constants and types for the port bitmap Bloom filter lookup block.
`default_nettype none

package pbbf_pkg;

    // Field widths fixed by the interface
    localparam int HASH_W   = 32;
    localparam int PORT_W   = 5;
    localparam int KIND_W   = 2;
    localparam int BITMAP_W = 32;

    // Default sizing
    localparam int DEF_FILTER_WORDS = 1024;
    localparam int DEF_PORTS        = 32;

    // Hash reduction: a reciprocal multiply, then the remainder with one correction
    localparam int MOD_STEPS = 2;
    localparam int CNT_W     = $clog2(MOD_STEPS);

    // Item modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // Result classification
    typedef enum logic [KIND_W-1:0] {
        KIND_NONE  = 2'd0,
        KIND_ONE   = 2'd1,
        KIND_MULTI = 2'd2
    } match_kind_t;

endpackage

`default_nettype wire

FILE: rtl/port_bitmap_bloom_filter_lookup_top.sv
// Top level: merged Bloom filter of port bitmaps, insert and query over one memory.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_valid / s_ready  | mode, hash_a, hash_b, hash_c, port
//  m_      | out | m_valid / m_ready  | match_kind, port_index, port_bitmap
//
// Items are accepted only in the idle state, one at a time. The MOD state reduces
// the three hashes modulo FILTER_WORDS (a reciprocal multiply, then the remainder
// with one correcting subtract, all three lanes at once); the states S_RDA to S_FIN
// read and write the filter memory through its one read port and one write port.
// After reset a clearing pass writes zero to every word, with s_ready low.
// A query waits in its last step while a previous result is not taken.
`default_nettype none

module port_bitmap_bloom_filter_lookup_top #(
    parameter int FILTER_WORDS = pbbf_pkg::DEF_FILTER_WORDS,
    parameter int PORTS        = pbbf_pkg::DEF_PORTS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_mode,
    input  wire logic [pbbf_pkg::HASH_W-1:0]   s_hash_a,
    input  wire logic [pbbf_pkg::HASH_W-1:0]   s_hash_b,
    input  wire logic [pbbf_pkg::HASH_W-1:0]   s_hash_c,
    input  wire logic [pbbf_pkg::PORT_W-1:0]   s_port,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [pbbf_pkg::KIND_W-1:0]        m_match_kind,
    output logic [pbbf_pkg::PORT_W-1:0]        m_port_index,
    output logic [pbbf_pkg::BITMAP_W-1:0]      m_port_bitmap
);

    localparam int IDX_W = $clog2(FILTER_WORDS);
    localparam logic [IDX_W:0]   MODULUS   = (IDX_W+1)'(FILTER_WORDS);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(FILTER_WORDS - 1);
    localparam int LANES = 3;
    localparam int PROD_W = 2 * pbbf_pkg::HASH_W;
    // 2^HASH_W / FILTER_WORDS, rounded down: the quotient estimate is low by at most one
    localparam logic [pbbf_pkg::HASH_W-1:0] RECIP =
        pbbf_pkg::HASH_W'((64'd1 << pbbf_pkg::HASH_W) / 64'(FILTER_WORDS));

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_RDA,
        S_RDB,
        S_RDC,
        S_FIN
    } state_t;

    // Registers
    state_t                          state_reg, state_next;
    logic [pbbf_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]                clr_addr_reg, clr_addr_next;
    logic                            mode_reg, mode_next;
    logic [PORTS-1:0]                bit_reg, bit_next;
    logic [pbbf_pkg::HASH_W-1:0]     hash_reg [LANES];
    logic [pbbf_pkg::HASH_W-1:0]     hash_next [LANES];
    logic [pbbf_pkg::HASH_W-1:0]     quot_reg [LANES];
    logic [pbbf_pkg::HASH_W-1:0]     quot_next [LANES];
    logic [IDX_W-1:0]                rem_reg [LANES];
    logic [IDX_W-1:0]                rem_next [LANES];
    logic [PORTS-1:0]                acc_reg, acc_next;
    logic                            m_valid_reg, m_valid_next;
    pbbf_pkg::match_kind_t           kind_reg, kind_next;
    logic [pbbf_pkg::PORT_W-1:0]     index_reg, index_next;
    logic [pbbf_pkg::BITMAP_W-1:0]   bitmap_reg, bitmap_next;

    // Filter memory and its port
    logic [PORTS-1:0]                mem [FILTER_WORDS];
    logic [PORTS-1:0]                rdata_reg;
    logic                            mem_re, mem_we;
    logic [IDX_W-1:0]                mem_raddr, mem_waddr;
    logic [PORTS-1:0]                mem_wdata;

    // Hash reduction step results
    logic [pbbf_pkg::HASH_W-1:0]     quot_est [LANES];
    logic [IDX_W-1:0]                rem_fix [LANES];

    // Query classification
    logic [PORTS-1:0]                hit;
    logic                            hit_single;
    logic [pbbf_pkg::PORT_W-1:0]     hit_index;

    logic                            s_fire;
    logic                            out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_match_kind  = kind_reg;
    assign m_port_index  = index_reg;
    assign m_port_bitmap = bitmap_reg;

    // Quotient estimate from the reciprocal; the remainder then lies below twice
    // the filter size, so its low bits suffice and one subtract corrects it
    always_comb begin : mod_step
        logic [PROD_W-1:0] prod;
        logic [IDX_W:0]    diff;
        prod = '0;
        diff = '0;
        for (int j = 0; j < LANES; j++) begin
            prod        = PROD_W'(hash_reg[j]) * PROD_W'(RECIP);
            quot_est[j] = prod[PROD_W-1:pbbf_pkg::HASH_W];
            diff        = hash_reg[j][IDX_W:0] - quot_reg[j][IDX_W:0] * MODULUS;
            if (diff >= MODULUS) begin
                diff = diff - MODULUS;
            end
            rem_fix[j] = diff[IDX_W-1:0];
        end
    end

    // Combine the three words and classify
    always_comb begin
        hit        = acc_reg & rdata_reg;
        hit_single = ((hit & (hit - PORTS'(1))) == '0);
        hit_index  = '0;
        for (int i = 0; i < PORTS; i++) begin
            if (hit[i]) begin
                hit_index = hit_index | pbbf_pkg::PORT_W'(i);
            end
        end
    end

    // Memory access per step. Insert writes OR the same bit, so a word picked
    // twice needs no forwarding: a stale read still ends in the same value.
    always_comb begin
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = rem_reg[0];
        mem_waddr = rem_reg[0];
        mem_wdata = rdata_reg | bit_reg;
        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            S_RDA: begin
                mem_re    = 1'b1;
                mem_raddr = rem_reg[0];
            end
            S_RDB: begin
                mem_re    = 1'b1;
                mem_raddr = rem_reg[1];
                mem_we    = (mode_reg == pbbf_pkg::MODE_INSERT);
                mem_waddr = rem_reg[0];
            end
            S_RDC: begin
                mem_re    = 1'b1;
                mem_raddr = rem_reg[2];
                mem_we    = (mode_reg == pbbf_pkg::MODE_INSERT);
                mem_waddr = rem_reg[1];
            end
            S_FIN: begin
                mem_we    = (mode_reg == pbbf_pkg::MODE_INSERT);
                mem_waddr = rem_reg[2];
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    // Filter memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Sequencer next state
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        clr_addr_next = clr_addr_reg;
        mode_next     = mode_reg;
        bit_next      = bit_reg;
        acc_next      = acc_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        kind_next     = kind_reg;
        index_next    = index_reg;
        bitmap_next   = bitmap_reg;
        for (int j = 0; j < LANES; j++) begin
            hash_next[j] = hash_reg[j];
            quot_next[j] = quot_reg[j];
            rem_next[j]  = rem_reg[j];
        end

        case (state_reg)
            S_CLEAR: begin
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    mode_next    = s_mode;
                    // a port at or beyond PORTS shifts out and sets nothing
                    bit_next     = PORTS'(1) << s_port;
                    hash_next[0] = s_hash_a;
                    hash_next[1] = s_hash_b;
                    hash_next[2] = s_hash_c;
                    for (int j = 0; j < LANES; j++) begin
                        rem_next[j] = '0;
                    end
                    cnt_next   = '0;
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                // first step loads the quotient, second the remainder from it
                for (int j = 0; j < LANES; j++) begin
                    quot_next[j] = quot_est[j];
                    rem_next[j]  = rem_fix[j];
                end
                cnt_next = cnt_reg + pbbf_pkg::CNT_W'(1);
                if (cnt_reg == pbbf_pkg::CNT_W'(pbbf_pkg::MOD_STEPS - 1)) begin
                    state_next = S_RDA;
                end
            end
            S_RDA: begin
                state_next = S_RDB;
            end
            S_RDB: begin
                acc_next   = rdata_reg;
                state_next = S_RDC;
            end
            S_RDC: begin
                acc_next   = acc_reg & rdata_reg;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (mode_reg == pbbf_pkg::MODE_INSERT) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    if (hit == '0) begin
                        kind_next   = pbbf_pkg::KIND_NONE;
                        index_next  = '0;
                        bitmap_next = '0;
                    end else if (hit_single) begin
                        kind_next   = pbbf_pkg::KIND_ONE;
                        index_next  = hit_index;
                        bitmap_next = '0;
                    end else begin
                        kind_next   = pbbf_pkg::KIND_MULTI;
                        index_next  = '0;
                        bitmap_next = pbbf_pkg::BITMAP_W'(hit);
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        mode_reg   <= mode_next;
        bit_reg    <= bit_next;
        acc_reg    <= acc_next;
        kind_reg   <= kind_next;
        index_reg  <= index_next;
        bitmap_reg <= bitmap_next;
        for (int j = 0; j < LANES; j++) begin
            hash_reg[j] <= hash_next[j];
            quot_reg[j] <= quot_next[j];
            rem_reg[j]  <= rem_next[j];
        end
    end

    // Checks
    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !m_valid)
        else $error("result valid during clearing pass");

    a_query_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg != S_CLEAR) |-> (mode_reg == pbbf_pkg::MODE_INSERT))
        else $error("filter written during a query");

    a_none_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_match_kind == pbbf_pkg::KIND_NONE)
            |-> (m_port_index == '0 && m_port_bitmap == '0))
        else $error("empty result carries a port");

    a_multi_has_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_match_kind == pbbf_pkg::KIND_MULTI) |-> ($countones(m_port_bitmap) >= 2))
        else $error("several-port result has fewer than two ports");

endmodule

`default_nettype wire
